[design/date_offset_calculator_assert.svh]
// ----------------------------------------------------------------------------
// date offset calculator assertion macros
// clocked concurrent assertion shorthands, reset masked
// ----------------------------------------------------------------------------
`ifndef DATE_OFFSET_CALCULATOR_ASSERT_SVH
`define DATE_OFFSET_CALCULATOR_ASSERT_SVH

// same-cycle implication
`define DOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/doc_pkg.sv]
// ----------------------------------------------------------------------------
// date offset calculator package
// shared widths, calendar constants and the month length table
// ----------------------------------------------------------------------------
package doc_pkg;

    localparam int SPAN_DAY_BITS_DEF = 16;
    localparam int SPAN_FIELD_W      = 16;
    localparam int MON_W             = 6;
    localparam int YEAR_W            = 17;
    localparam int MONTHS            = 12;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int YEAR_MAX          = 9999;

    typedef struct packed {
        logic done;
        logic out_of_range;
    } doc_status_t;

    // non-leap month lengths, index 0 is january
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[design/date_offset_calculator.sv]
// ----------------------------------------------------------------------------
// date offset calculator
// adds a span of days, months and years to a date, or subtracts it, on a
// calendar with no leap years; month range, then whole years of days, then days month by month
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                          tuser
//  s_        in         day 5, month 4, year 14, span days 16,       operation
//                       span months 4, span years 14, pad 7
//  m_        out        day 5, month 4, year 14, out of range 1      -
//
//  a transaction runs through month wraps, then whole years of days, then
//  month carries or borrows; the single day adder in the step unit moves
//  one step per cycle. s_tready is high only while idle. a finished result
//  waits in the output register; a following transaction is accepted and
//  held there at its end until the output register frees. reset is sync.
// ----------------------------------------------------------------------------
module date_offset_calculator #(
    parameter int SPAN_DAY_BITS = doc_pkg::SPAN_DAY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // start_day, start_month, start_year, span_days,
                                  // span_months, span_years
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // result_day, result_month, result_year, out_of_range
);
    import doc_pkg::*;

    localparam int USED_W = (SPAN_DAY_BITS < SPAN_FIELD_W) ? SPAN_DAY_BITS : SPAN_FIELD_W;
    localparam int DAY_W  = USED_W + 2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [DAY_W-1:0]   day_reg, day_next;
    logic signed [MON_W-1:0]   mon_reg, mon_next;
    logic signed [YEAR_W-1:0]  year_reg, year_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic        [23:0]        m_tdata_reg, m_tdata_next;

    logic signed [DAY_W-1:0]   day_step;
    logic signed [MON_W-1:0]   mon_step;
    logic signed [YEAR_W-1:0]  year_step;
    logic        [13:0]        year_clamp;
    doc_status_t               status;

    logic signed [DAY_W-1:0]   in_day, in_span_day;
    logic signed [MON_W-1:0]   in_mon, in_span_mon;
    logic signed [YEAR_W-1:0]  in_year, in_span_year;
    logic                      in_accept;
    logic                      out_free;

    assign in_accept    = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;

    assign in_day       = $signed({{(DAY_W-5){1'b0}}, s_tdata[4:0]});
    assign in_mon       = $signed({{(MON_W-4){1'b0}}, s_tdata[8:5]});
    assign in_year      = $signed({{(YEAR_W-14){1'b0}}, s_tdata[22:9]});
    assign in_span_day  = $signed({2'b00, s_tdata[23 +: USED_W]});
    assign in_span_mon  = $signed({{(MON_W-4){1'b0}}, s_tdata[42:39]});
    assign in_span_year = $signed({{(YEAR_W-14){1'b0}}, s_tdata[56:43]});

    doc_step_unit #(
        .DAY_W (DAY_W)
    ) u_step (
        .day_i        (day_reg),
        .mon_i        (mon_reg),
        .year_i       (year_reg),
        .day_o        (day_step),
        .mon_o        (mon_step),
        .year_o       (year_step),
        .year_clamp_o (year_clamp),
        .status_o     (status)
    );

    always_comb begin
        state_next    = state_reg;
        day_next      = day_reg;
        mon_next      = mon_reg;
        year_next     = year_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser) begin
                        day_next  = in_day - in_span_day;
                        mon_next  = in_mon - in_span_mon;
                        year_next = in_year - in_span_year;
                    end else begin
                        day_next  = in_day + in_span_day;
                        mon_next  = in_mon + in_span_mon;
                        year_next = in_year + in_span_year;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!status.done) begin
                    day_next  = day_step;
                    mon_next  = mon_step;
                    year_next = year_step;
                end else if (out_free) begin
                    m_tdata_next  = {status.out_of_range, year_clamp, mon_reg[3:0],
                                     day_reg[4:0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        day_reg     <= day_next;
        mon_reg     <= mon_next;
        year_reg    <= year_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/doc_step_unit.sv]
// ----------------------------------------------------------------------------
// date offset step unit
// one normalization step per call: month wrap, year of days, month carry
// or month borrow, through a single day adder; also clamps the final year
// ----------------------------------------------------------------------------
module doc_step_unit #(
    parameter int DAY_W = doc_pkg::SPAN_DAY_BITS_DEF + 2
) (
    input  logic signed [DAY_W-1:0]          day_i,
    input  logic signed [doc_pkg::MON_W-1:0]  mon_i,
    input  logic signed [doc_pkg::YEAR_W-1:0] year_i,
    output logic signed [DAY_W-1:0]          day_o,
    output logic signed [doc_pkg::MON_W-1:0]  mon_o,
    output logic signed [doc_pkg::YEAR_W-1:0] year_o,
    output logic        [13:0]               year_clamp_o,
    output doc_pkg::doc_status_t             status_o
);
    import doc_pkg::*;

    localparam logic signed [MON_W-1:0]  MON_TOP   = MON_W'(MONTHS);
    localparam logic signed [MON_W-1:0]  MON_ONE   = MON_W'(1);
    localparam logic signed [DAY_W-1:0]  DAY_YEAR  = DAY_W'(DAYS_PER_YEAR);
    localparam logic signed [DAY_W-1:0]  DAY_NYEAR = -DAY_W'(DAYS_PER_YEAR);
    localparam logic signed [DAY_W-1:0]  DAY_ONE   = DAY_W'(1);
    localparam logic signed [YEAR_W-1:0] YEAR_ONE  = YEAR_W'(1);
    localparam logic signed [YEAR_W-1:0] YEAR_TOP  = YEAR_W'(YEAR_MAX);
    localparam logic signed [YEAR_W-1:0] YEAR_ZERO = '0;

    logic        [4:0]              cur_len;
    logic        [4:0]              prev_len;
    logic signed [MON_W-1:0]        prev_mon;
    logic signed [DAY_W-1:0]        cur_len_s;
    logic signed [DAY_W-1:0]        prev_len_s;
    logic signed [DAY_W-1:0]        addend;
    logic                           done;

    assign cur_len    = month_len(mon_i[3:0] - 4'd1);
    assign prev_mon   = (mon_i == MON_ONE) ? MON_TOP : mon_i - MON_ONE;
    assign prev_len   = month_len(prev_mon[3:0] - 4'd1);
    assign cur_len_s  = $signed({{(DAY_W-5){1'b0}}, cur_len});
    assign prev_len_s = $signed({{(DAY_W-5){1'b0}}, prev_len});

    always_comb begin
        addend = '0;
        mon_o  = mon_i;
        year_o = year_i;
        done   = 1'b0;
        if (mon_i > MON_TOP) begin
            mon_o  = mon_i - MON_TOP;
            year_o = year_i + YEAR_ONE;
        end else if (mon_i < MON_ONE) begin
            mon_o  = mon_i + MON_TOP;
            year_o = year_i - YEAR_ONE;
        end else if (day_i > DAY_YEAR) begin
            addend = DAY_NYEAR;
            year_o = year_i + YEAR_ONE;
        end else if (day_i < DAY_NYEAR) begin
            addend = DAY_YEAR;
            year_o = year_i - YEAR_ONE;
        end else if (day_i > cur_len_s) begin
            addend = -cur_len_s;
            if (mon_i == MON_TOP) begin
                mon_o  = MON_ONE;
                year_o = year_i + YEAR_ONE;
            end else begin
                mon_o = mon_i + MON_ONE;
            end
        end else if (day_i < DAY_ONE) begin
            addend = prev_len_s;
            mon_o  = prev_mon;
            if (mon_i == MON_ONE) begin
                year_o = year_i - YEAR_ONE;
            end
        end else begin
            done = 1'b1;
        end
        day_o = day_i + addend;
    end

    always_comb begin
        status_o.done = done;
        if (year_i < YEAR_ZERO) begin
            year_clamp_o          = '0;
            status_o.out_of_range = 1'b1;
        end else if (year_i > YEAR_TOP) begin
            year_clamp_o          = YEAR_TOP[13:0];
            status_o.out_of_range = 1'b1;
        end else begin
            year_clamp_o          = year_i[13:0];
            status_o.out_of_range = 1'b0;
        end
    end

endmodule

[design/doc_checker.sv]
// ----------------------------------------------------------------------------
// date offset calculator checker
// port-level checks on result ranges, clamping and transaction pacing
// ----------------------------------------------------------------------------
`include "date_offset_calculator_assert.svh"

module doc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `DOC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")

    `DOC_ASSERT_NOW(a_date_range, m_tvalid, m_tdata[8:5] >= 4'd1 && m_tdata[8:5] <= 4'd12 && m_tdata[4:0] != 5'd0, "result date out of range")

    `DOC_ASSERT_NOW(a_year_max, m_tvalid, m_tdata[22:9] <= 14'd9999, "result year above limit")

    `DOC_ASSERT_NOW(a_clamp, m_tvalid && m_tdata[23], m_tdata[22:9] == 14'd0 || m_tdata[22:9] == 14'd9999, "flagged year not clamped")

    `DOC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind date_offset_calculator doc_checker u_doc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/tb_date_offset_calculator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date offset calculator testbench
// drives dated requests into the stream input and checks each returned date
// against a calendar predictor (no leap years); directed corner dates first,
// then random requests under several sender and receiver idling phases
// ----------------------------------------------------------------------------

typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        out_of_range;
} date_result_t;

class date_scoreboard;
    date_result_t expected_dates[$];
    int           failures = 0;
    int           month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // predict the date for one accepted request transaction
    function void note_request(input bit subtract, input logic [63:0] d);
        int           day;
        int           mon;
        int           yr;
        int           span_d;
        int           span_m;
        int           span_y;
        date_result_t r;
        span_d = int'(d[38:23]);
        span_m = int'(d[42:39]);
        span_y = int'(d[56:43]);
        if (subtract) begin
            day = int'(d[4:0]) - span_d;
            mon = int'(d[8:5]) - span_m;
            yr  = int'(d[22:9]) - span_y;
        end else begin
            day = int'(d[4:0]) + span_d;
            mon = int'(d[8:5]) + span_m;
            yr  = int'(d[22:9]) + span_y;
        end
        while (mon > 12) begin
            mon -= 12;
            yr++;
        end
        while (mon < 1) begin
            mon += 12;
            yr--;
        end
        while (day > 365) begin
            day -= 365;
            yr++;
        end
        while (day < -365) begin
            day += 365;
            yr--;
        end
        while (day > month_days[mon - 1]) begin
            day -= month_days[mon - 1];
            mon++;
            if (mon > 12) begin
                mon = 1;
                yr++;
            end
        end
        // borrow takes the previous month's length
        while (day < 1) begin
            mon--;
            if (mon < 1) begin
                mon = 12;
                yr--;
            end
            day += month_days[mon - 1];
        end
        r.out_of_range = 1'b0;
        if (yr < 0) begin
            yr = 0;
            r.out_of_range = 1'b1;
        end else if (yr > 9999) begin
            yr = 9999;
            r.out_of_range = 1'b1;
        end
        r.day   = day[4:0];
        r.month = mon[3:0];
        r.year  = yr[13:0];
        expected_dates.push_back(r);
    endfunction

    function void check_result(input logic [23:0] m);
        date_result_t e;
        if (expected_dates.size() == 0) begin
            $error("unexpected result transaction: %h", m);
            failures++;
            return;
        end
        e = expected_dates.pop_front();
        if (m[4:0] !== e.day) begin
            $error("result_day mismatch: expected %0d, actual %0d", e.day, m[4:0]);
            failures++;
        end
        if (m[8:5] !== e.month) begin
            $error("result_month mismatch: expected %0d, actual %0d", e.month, m[8:5]);
            failures++;
        end
        if (m[22:9] !== e.year) begin
            $error("result_year mismatch: expected %0d, actual %0d", e.year, m[22:9]);
            failures++;
        end
        if (m[23] !== e.out_of_range) begin
            $error("out_of_range mismatch: expected %0d, actual %0d", e.out_of_range, m[23]);
            failures++;
        end
    endfunction

    function int pending();
        return expected_dates.size();
    endfunction
endclass

module tb_date_offset_calculator;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 250;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam bit OP_ADD = 1'b0;
    localparam bit OP_SUB = 1'b1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    date_scoreboard sb;

    date_offset_calculator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [63:0] pack_request(input logic [4:0] day,
                                                 input logic [3:0] mon,
                                                 input logic [13:0] yr,
                                                 input logic [15:0] span_d,
                                                 input logic [3:0] span_m,
                                                 input logic [13:0] span_y);
        return {7'd0, span_y, span_m, span_d, yr, mon, day};
    endfunction

    task automatic send_request(input bit op, input logic [63:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, d);
    endtask

    task automatic send_date(input bit op, input int day, input int mon, input int yr,
                             input int span_d, input int span_m, input int span_y);
        send_request(op, pack_request(5'(day), 4'(mon), 14'(yr), 16'(span_d), 4'(span_m),
                                      14'(span_y)));
    endtask

    task automatic send_random_request();
        int kind;
        int day;
        int mon;
        int yr;
        int span_d;
        int span_m;
        int span_y;
        kind = $urandom_range(99);
        if (kind < 25) begin
            // any field value, including malformed dates
            day    = $urandom_range(31);
            mon    = $urandom_range(15);
            yr     = $urandom_range(16383);
            span_d = $urandom_range(65535);
            span_m = $urandom_range(15);
            span_y = $urandom_range(16383);
        end else begin
            day = $urandom_range(31, 1);
            mon = $urandom_range(12, 1);
            yr  = $urandom_range(9999);
            if ($urandom_range(9) == 0) begin
                yr = $urandom_range(1) ? $urandom_range(5) : $urandom_range(9999, 9994);
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                span_d = $urandom_range(400);
            end else if (kind < 95) begin
                span_d = $urandom_range(3000);
            end else begin
                span_d = $urandom_range(65535);
            end
            span_m = $urandom_range(12);
            span_y = ($urandom_range(4) == 0) ? $urandom_range(9999) : $urandom_range(100);
        end
        send_date($urandom_range(1), day, mon, yr, span_d, span_m, span_y);
    endtask

    // result sink, checking and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        sb = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corner dates
        send_date(OP_ADD, 1, 1, 2000, 0, 0, 0);
        send_date(OP_ADD, 31, 12, 1999, 1, 0, 0);
        send_date(OP_SUB, 1, 1, 2000, 1, 0, 0);
        send_date(OP_SUB, 1, 3, 2001, 1, 0, 0);
        send_date(OP_ADD, 31, 2, 2001, 0, 0, 0);
        send_date(OP_ADD, 0, 5, 2001, 0, 0, 0);
        send_date(OP_SUB, 0, 1, 2001, 0, 0, 0);
        send_date(OP_ADD, 15, 0, 2001, 0, 0, 0);
        send_date(OP_ADD, 15, 15, 2001, 0, 15, 0);
        send_date(OP_SUB, 15, 0, 2001, 0, 15, 0);
        send_date(OP_SUB, 1, 1, 0, 1, 0, 0);
        send_date(OP_ADD, 31, 12, 9999, 1, 0, 0);
        send_date(OP_ADD, 10, 6, 16383, 0, 0, 0);
        send_date(OP_SUB, 10, 6, 16383, 0, 0, 9000);
        send_date(OP_ADD, 1, 1, 0, 65535, 0, 0);
        send_date(OP_SUB, 31, 12, 9999, 65535, 0, 0);
        send_date(OP_ADD, 31, 15, 16383, 65535, 15, 16383);
        send_date(OP_SUB, 0, 0, 0, 65535, 15, 16383);
        send_date(OP_ADD, 0, 0, 0, 0, 0, 0);
        send_date(OP_ADD, 28, 2, 5000, 365, 12, 0);
        send_date(OP_SUB, 28, 2, 5000, 365, 12, 0);
        send_date(OP_ADD, 31, 1, 100, 29, 1, 0);

        // random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 64;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 64;
                end
                default: begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            repeat (RANDOM_ITEMS / 4) send_random_request();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
